// ----- rtl/sjfs_pkg.sv -----
// ----------------------------------------------------------------------------
// sjfs_pkg: shared definitions for the shortest-job-first scheduler
// Default sizes, fixed port widths and the control word sent to every cell.
// ----------------------------------------------------------------------------
package sjfs_pkg;

   // default sizes
   localparam int MAX_JOBS_DEF  = 16;
   localparam int TIME_BITS_DEF = 16;

   // fixed port widths
   localparam int ID_W   = 5;
   localparam int TIME_W = 16;
   localparam int DUR_W  = 21;
   localparam int SUM_W  = 25;
   localparam int CNT_W  = 5;

   // control word broadcast to the row of cells
   typedef struct packed {
      logic wr_en;    // store the incoming job in the addressed cell
      logic mark_en;  // flag the addressed cell as scheduled
      logic clear;    // drop all done flags for a new set
   } cell_ctrl_type;

endpackage

// ----- rtl/sjfs_cell.sv -----
// ----------------------------------------------------------------------------
// sjfs_cell: one job slot of the scheduler row
// Holds a job and folds it into the best-candidate and earliest-pending words
// that travel down the row, one register stage per cell.
// ----------------------------------------------------------------------------
module sjfs_cell
   import sjfs_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEF,
   parameter int CT_BITS   = TIME_BITS_DEF + 5,
   parameter int IDX_BITS  = 4,
   parameter int CNT_BITS  = 5,
   parameter int CELL_ID   = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cell_ctrl_type        ctrl,
   input  logic [IDX_BITS-1:0]  sel_idx,
   input  logic [TIME_BITS-1:0] wr_arrival,
   input  logic [TIME_BITS-1:0] wr_burst,
   input  logic [CNT_BITS-1:0]  count,
   input  logic [CT_BITS-1:0]   cur_time,
   input  logic                 in_bvalid,
   input  logic [TIME_BITS-1:0] in_burst,
   input  logic [TIME_BITS-1:0] in_barr,
   input  logic [IDX_BITS-1:0]  in_bid,
   input  logic                 in_pvalid,
   input  logic [TIME_BITS-1:0] in_pmin,
   output logic                 out_bvalid,
   output logic [TIME_BITS-1:0] out_burst,
   output logic [TIME_BITS-1:0] out_barr,
   output logic [IDX_BITS-1:0]  out_bid,
   output logic                 out_pvalid,
   output logic [TIME_BITS-1:0] out_pmin
);

   localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(CELL_ID);

   logic [TIME_BITS-1:0] arr_ff, burst_ff;
   logic                 done_ff, done_in;
   logic                 bvalid_ff, pvalid_ff;
   logic [TIME_BITS-1:0] bburst_ff, barr_ff, pmin_ff;
   logic [IDX_BITS-1:0]  bid_ff;
   logic                 hit, active, pending, ready, take_best, take_pend;

   // slot decode and candidate tests
   always_comb begin
      hit       = (sel_idx == MY_IDX);
      active    = (CNT_BITS'(CELL_ID) < count);
      pending   = active && !done_ff;
      ready     = pending && (CT_BITS'(arr_ff) <= cur_time);
      take_best = ready && (!in_bvalid || (burst_ff < in_burst) ||
                  ((burst_ff == in_burst) && (arr_ff < in_barr)));
      take_pend = pending && (!in_pvalid || (arr_ff < in_pmin));
      done_in   = done_ff;
      if (ctrl.clear) begin
         done_in = 1'b0;
      end else if (ctrl.wr_en && hit) begin
         done_in = 1'b0;
      end else if (ctrl.mark_en && hit) begin
         done_in = 1'b1;
      end
   end

   // job storage, done flag and the outgoing row words
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff   <= 1'b0;
         bvalid_ff <= 1'b0;
         pvalid_ff <= 1'b0;
      end else begin
         done_ff   <= done_in;
         bvalid_ff <= in_bvalid || take_best;
         pvalid_ff <= in_pvalid || take_pend;
      end
      if (ctrl.wr_en && hit) begin
         arr_ff   <= wr_arrival;
         burst_ff <= wr_burst;
      end
      bburst_ff <= take_best ? burst_ff : in_burst;
      barr_ff   <= take_best ? arr_ff : in_barr;
      bid_ff    <= take_best ? MY_IDX : in_bid;
      pmin_ff   <= take_pend ? arr_ff : in_pmin;
   end

   assign out_bvalid = bvalid_ff;
   assign out_burst  = bburst_ff;
   assign out_barr   = barr_ff;
   assign out_bid    = bid_ff;
   assign out_pvalid = pvalid_ff;
   assign out_pmin   = pmin_ff;

endmodule

// ----- rtl/sjf_nonpreemptive_scheduler.sv -----
// ----------------------------------------------------------------------------
// sjf_nonpreemptive_scheduler: non-preemptive shortest-job-first scheduler
// Loads a job set, then emits one word per job in run order with wait,
// turnaround and running totals.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_ready  arrival, burst, last_job
//  rsp      out        rsp_valid/rsp_ready  id, times, totals, count, flags
//
//  loading accepts one req word per cycle; the word marked last starts the run
//  each result takes a scan of the whole row plus an evaluate step,
//  and one more scan plus evaluate step when the clock has to jump an idle gap
//  a result holds in the output register until taken
//  reset is synchronous and clears control state; job slots need no clearing
//  req_ready is low for the whole run, from the last word to the last result
module sjf_nonpreemptive_scheduler
   import sjfs_pkg::*;
#(
   parameter int MAX_JOBS  = MAX_JOBS_DEF,
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [TIME_W-1:0] req_arrival_time,
   input  logic [TIME_W-1:0] req_burst_time,
   input  logic              req_last_job,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [ID_W-1:0]   rsp_job_id,
   output logic [TIME_W-1:0] rsp_job_arrival,
   output logic [TIME_W-1:0] rsp_job_burst,
   output logic [DUR_W-1:0]  rsp_wait_time,
   output logic [DUR_W-1:0]  rsp_turnaround_time,
   output logic [SUM_W-1:0]  rsp_total_wait,
   output logic [SUM_W-1:0]  rsp_total_turnaround,
   output logic [CNT_W-1:0]  rsp_job_count,
   output logic              rsp_dropped,
   output logic              rsp_last_result
);

   localparam int IDX_BITS = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CNT_BITS = $clog2(MAX_JOBS + 1);
   localparam int CT_BITS  = TIME_BITS + $clog2(MAX_JOBS + 1);

   typedef enum logic [1:0] {ST_LOAD, ST_SCAN, ST_EVAL, ST_OUT} state_type;

   state_type               state_ff, state_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [CNT_BITS-1:0]     k_ff, k_in;
   logic [IDX_BITS-1:0]     scan_ff, scan_in;
   logic                    ovf_ff, ovf_in;
   logic [CT_BITS-1:0]      ct_ff, ct_in;
   logic [SUM_W-1:0]        wsum_ff, wsum_in, tsum_ff, tsum_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]         id_ff, id_in;
   logic [TIME_W-1:0]       arr_ff, arr_in, bur_ff, bur_in;
   logic [DUR_W-1:0]        w_ff, w_in, t_ff, t_in;
   logic                    last_ff, last_in;

   cell_ctrl_type           ctrl;
   logic [IDX_BITS-1:0]     sel_idx;
   logic                    req_acc, rsp_acc, has_room;
   logic [CT_BITS-1:0]      w_full, t_full, best_arr_ct, best_bur_ct;

   // row words between cells, entry 0 is the empty word fed to the first cell
   logic                    tok_bvalid [0:MAX_JOBS];
   logic [TIME_BITS-1:0]    tok_burst  [0:MAX_JOBS];
   logic [TIME_BITS-1:0]    tok_barr   [0:MAX_JOBS];
   logic [IDX_BITS-1:0]     tok_bid    [0:MAX_JOBS];
   logic                    tok_pvalid [0:MAX_JOBS];
   logic [TIME_BITS-1:0]    tok_pmin   [0:MAX_JOBS];

   assign tok_bvalid[0] = 1'b0;
   assign tok_burst[0]  = '0;
   assign tok_barr[0]   = '0;
   assign tok_bid[0]    = '0;
   assign tok_pvalid[0] = 1'b0;
   assign tok_pmin[0]   = '0;

   // row of job cells
   for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
      sjfs_cell #(
         .TIME_BITS (TIME_BITS),
         .CT_BITS   (CT_BITS),
         .IDX_BITS  (IDX_BITS),
         .CNT_BITS  (CNT_BITS),
         .CELL_ID   (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .sel_idx    (sel_idx),
         .wr_arrival (TIME_BITS'(req_arrival_time)),
         .wr_burst   (TIME_BITS'(req_burst_time)),
         .count      (count_ff),
         .cur_time   (ct_ff),
         .in_bvalid  (tok_bvalid[i]),
         .in_burst   (tok_burst[i]),
         .in_barr    (tok_barr[i]),
         .in_bid     (tok_bid[i]),
         .in_pvalid  (tok_pvalid[i]),
         .in_pmin    (tok_pmin[i]),
         .out_bvalid (tok_bvalid[i+1]),
         .out_burst  (tok_burst[i+1]),
         .out_barr   (tok_barr[i+1]),
         .out_bid    (tok_bid[i+1]),
         .out_pvalid (tok_pvalid[i+1]),
         .out_pmin   (tok_pmin[i+1])
      );
   end

   // timing of the selected job
   always_comb begin
      best_arr_ct = CT_BITS'(tok_barr[MAX_JOBS]);
      best_bur_ct = CT_BITS'(tok_burst[MAX_JOBS]);
      w_full      = ct_ff - best_arr_ct;
      t_full      = w_full + best_bur_ct;
   end

   // next-state and control
   always_comb begin
      req_acc      = (state_ff == ST_LOAD) && req_valid;
      rsp_acc      = rsp_valid_ff && rsp_ready;
      has_room     = (count_ff < CNT_BITS'(MAX_JOBS));
      state_in     = state_ff;
      count_in     = count_ff;
      k_in         = k_ff;
      scan_in      = scan_ff;
      ovf_in       = ovf_ff;
      ct_in        = ct_ff;
      wsum_in      = wsum_ff;
      tsum_in      = tsum_ff;
      rsp_valid_in = rsp_valid_ff;
      id_in        = id_ff;
      arr_in       = arr_ff;
      bur_in       = bur_ff;
      w_in         = w_ff;
      t_in         = t_ff;
      last_in      = last_ff;
      ctrl         = '0;
      sel_idx      = count_ff[IDX_BITS-1:0];
      case (state_ff)
         ST_LOAD: begin
            if (req_acc) begin
               if (has_room) begin
                  ctrl.wr_en = 1'b1;
                  count_in   = count_ff + CNT_BITS'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last_job) begin
                  state_in = ST_SCAN;
                  scan_in  = '0;
                  k_in     = '0;
               end
            end
         end
         ST_SCAN: begin
            scan_in = scan_ff + IDX_BITS'(1);
            if (scan_ff == IDX_BITS'(MAX_JOBS - 1)) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            sel_idx = tok_bid[MAX_JOBS];
            scan_in = '0;
            if (tok_bvalid[MAX_JOBS]) begin
               // schedule the best ready job
               ctrl.mark_en = 1'b1;
               ct_in        = ct_ff + best_bur_ct;
               wsum_in      = wsum_ff + SUM_W'(w_full);
               tsum_in      = tsum_ff + SUM_W'(t_full);
               id_in        = ID_W'(tok_bid[MAX_JOBS]) + ID_W'(1);
               arr_in       = TIME_W'(tok_barr[MAX_JOBS]);
               bur_in       = TIME_W'(tok_burst[MAX_JOBS]);
               w_in         = DUR_W'(w_full);
               t_in         = DUR_W'(t_full);
               last_in      = ((k_ff + CNT_BITS'(1)) == count_ff);
               k_in         = k_ff + CNT_BITS'(1);
               rsp_valid_in = 1'b1;
               state_in     = ST_OUT;
            end else if (tok_pvalid[MAX_JOBS]) begin
               // idle gap: jump to the earliest pending arrival and rescan
               ct_in    = CT_BITS'(tok_pmin[MAX_JOBS]);
               state_in = ST_SCAN;
            end else begin
               ctrl.clear = 1'b1;
               count_in   = '0;
               ovf_in     = 1'b0;
               ct_in      = '0;
               wsum_in    = '0;
               tsum_in    = '0;
               state_in   = ST_LOAD;
            end
         end
         ST_OUT: begin
            if (rsp_acc) begin
               rsp_valid_in = 1'b0;
               if (last_ff) begin
                  ctrl.clear = 1'b1;
                  count_in   = '0;
                  ovf_in     = 1'b0;
                  ct_in      = '0;
                  wsum_in    = '0;
                  tsum_in    = '0;
                  state_in   = ST_LOAD;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         k_ff         <= '0;
         scan_ff      <= '0;
         ovf_ff       <= 1'b0;
         ct_ff        <= '0;
         wsum_ff      <= '0;
         tsum_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         k_ff         <= k_in;
         scan_ff      <= scan_in;
         ovf_ff       <= ovf_in;
         ct_ff        <= ct_in;
         wsum_ff      <= wsum_in;
         tsum_ff      <= tsum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      id_ff   <= id_in;
      arr_ff  <= arr_in;
      bur_ff  <= bur_in;
      w_ff    <= w_in;
      t_ff    <= t_in;
      last_ff <= last_in;
   end

   assign req_ready            = (state_ff == ST_LOAD);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_job_id           = id_ff;
   assign rsp_job_arrival      = arr_ff;
   assign rsp_job_burst        = bur_ff;
   assign rsp_wait_time        = w_ff;
   assign rsp_turnaround_time  = t_ff;
   assign rsp_total_wait       = wsum_ff;
   assign rsp_total_turnaround = tsum_ff;
   assign rsp_job_count        = CNT_W'(count_ff);
   assign rsp_dropped          = ovf_ff;
   assign rsp_last_result      = last_ff;

   // loading and result delivery never overlap
   assert property (@(posedge clock) disable iff (reset) !(req_ready && rsp_valid))
      else $error("req_ready and rsp_valid high together");

   // a word's id lies inside the loaded set
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (MAX_JOBS > 30) ||
                    ((rsp_job_id != '0) && (rsp_job_id <= rsp_job_count)))
      else $error("job id outside loaded set");

   // turnaround is wait plus burst
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (TIME_BITS > TIME_W) ||
                    (rsp_turnaround_time == DUR_W'(rsp_wait_time + DUR_W'(rsp_job_burst))))
      else $error("turnaround does not match wait plus burst");

   // the final word of a run frees the block for a new set
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_result) |=> (req_ready && !rsp_valid))
      else $error("block not back to loading after final word");

   // the selected job always belongs to the loaded set
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EVAL) && tok_bvalid[MAX_JOBS]) |->
         (CNT_BITS'(tok_bid[MAX_JOBS]) < count_ff))
      else $error("selected slot beyond loaded count");

endmodule

// ----- sim/sjfs_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjfs_checker: run-order scoreboard for the shortest-job-first scheduler
// Watches both channels, keeps its own copy of the loaded job set, works out
// the whole run order when the closing word of a set is taken, and compares
// every result word field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module sjfs_checker
   import sjfs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [TIME_W-1:0] req_arrival_time,
   input  logic [TIME_W-1:0] req_burst_time,
   input  logic              req_last_job,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [ID_W-1:0]   rsp_job_id,
   input  logic [TIME_W-1:0] rsp_job_arrival,
   input  logic [TIME_W-1:0] rsp_job_burst,
   input  logic [DUR_W-1:0]  rsp_wait_time,
   input  logic [DUR_W-1:0]  rsp_turnaround_time,
   input  logic [SUM_W-1:0]  rsp_total_wait,
   input  logic [SUM_W-1:0]  rsp_total_turnaround,
   input  logic [CNT_W-1:0]  rsp_job_count,
   input  logic              rsp_dropped,
   input  logic              rsp_last_result,
   output int                errors,
   output int                pending
);

   typedef struct {
      logic [ID_W-1:0]   job_id;
      logic [TIME_W-1:0] job_arrival;
      logic [TIME_W-1:0] job_burst;
      logic [DUR_W-1:0]  wait_time;
      logic [DUR_W-1:0]  turnaround_time;
      logic [SUM_W-1:0]  total_wait;
      logic [SUM_W-1:0]  total_turnaround;
      logic [CNT_W-1:0]  job_count;
      logic              dropped;
      logic              last_result;
   } job_result_type;

   // predicted result words, oldest first
   job_result_type run_order_q[$];

   // shadow copy of the loaded job set
   logic [TIME_W-1:0] arrival_mem[MAX_JOBS_DEF];
   logic [TIME_W-1:0] burst_mem[MAX_JOBS_DEF];
   bit                ran_mem[MAX_JOBS_DEF];
   int unsigned       stored_jobs;
   bit                set_overflow;

   // best arrived job at tick now: shortest burst, then earliest arrival,
   // then lowest index through the strict compares
   function automatic int pick_shortest(longint unsigned now);
      int best;
      int i;
      best = -1;
      for (i = 0; i < stored_jobs; i++) begin
         if (!ran_mem[i] && arrival_mem[i] <= now) begin
            if (best < 0 || burst_mem[i] < burst_mem[best] ||
                (burst_mem[i] == burst_mem[best] &&
                 arrival_mem[i] < arrival_mem[best]))
               best = i;
         end
      end
      return best;
   endfunction

   // whole run of the stored set, then back to an empty set
   task automatic schedule_set();
      longint unsigned now;
      longint unsigned wait_t;
      longint unsigned turn_t;
      longint unsigned wait_acc;
      longint unsigned turn_acc;
      longint unsigned soonest;
      int              sel;
      int              k;
      int              i;
      job_result_type  r;
      now      = 0;
      wait_acc = 0;
      turn_acc = 0;
      for (k = 0; k < stored_jobs; k++) begin
         sel = pick_shortest(now);
         // idle gap: jump to the earliest pending arrival
         if (sel < 0) begin
            soonest = {64{1'b1}};
            for (i = 0; i < stored_jobs; i++)
               if (!ran_mem[i] && arrival_mem[i] < soonest)
                  soonest = arrival_mem[i];
            now = soonest;
            sel = pick_shortest(now);
            if (sel < 0)
               break;
         end
         wait_t   = now - arrival_mem[sel];
         now      = now + burst_mem[sel];
         turn_t   = now - arrival_mem[sel];
         wait_acc = wait_acc + wait_t;
         turn_acc = turn_acc + turn_t;
         ran_mem[sel] = 1'b1;
         r.job_id           = ID_W'(sel + 1);
         r.job_arrival      = arrival_mem[sel];
         r.job_burst        = burst_mem[sel];
         r.wait_time        = DUR_W'(wait_t);
         r.turnaround_time  = DUR_W'(turn_t);
         r.total_wait       = SUM_W'(wait_acc);
         r.total_turnaround = SUM_W'(turn_acc);
         r.job_count        = CNT_W'(stored_jobs);
         r.dropped          = set_overflow;
         r.last_result      = (k + 1 == stored_jobs);
         run_order_q.push_back(r);
      end
      for (i = 0; i < MAX_JOBS_DEF; i++)
         ran_mem[i] = 1'b0;
      stored_jobs  = 0;
      set_overflow = 1'b0;
   endtask

   function automatic void check_field(string name, longint unsigned exp_v,
                                       longint unsigned act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         errors++;
      end
   endfunction

   initial begin
      errors       = 0;
      pending      = 0;
      stored_jobs  = 0;
      set_overflow = 1'b0;
      foreach (ran_mem[i])
         ran_mem[i] = 1'b0;
   end

   always @(posedge clock) begin
      job_result_type e;
      if (reset) begin
         run_order_q.delete();
         stored_jobs  = 0;
         set_overflow = 1'b0;
         foreach (ran_mem[i])
            ran_mem[i] = 1'b0;
      end else begin
         // job word taken: store it or flag the overflow
         if (req_valid && req_ready) begin
            if (stored_jobs < MAX_JOBS_DEF) begin
               arrival_mem[stored_jobs] = req_arrival_time;
               burst_mem[stored_jobs]   = req_burst_time;
               ran_mem[stored_jobs]     = 1'b0;
               stored_jobs++;
            end else begin
               set_overflow = 1'b1;
            end
            if (req_last_job)
               schedule_set();
         end
         // result word taken: compare with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (run_order_q.size() == 0) begin
               $error("result word with none predicted: job_id %0d", rsp_job_id);
               errors++;
            end else begin
               e = run_order_q.pop_front();
               check_field("job_id", e.job_id, rsp_job_id);
               check_field("job_arrival", e.job_arrival, rsp_job_arrival);
               check_field("job_burst", e.job_burst, rsp_job_burst);
               check_field("wait_time", e.wait_time, rsp_wait_time);
               check_field("turnaround_time", e.turnaround_time, rsp_turnaround_time);
               check_field("total_wait", e.total_wait, rsp_total_wait);
               check_field("total_turnaround", e.total_turnaround,
                           rsp_total_turnaround);
               check_field("job_count", e.job_count, rsp_job_count);
               check_field("dropped", e.dropped, rsp_dropped);
               check_field("last_result", e.last_result, rsp_last_result);
            end
         end
      end
      pending = run_order_q.size();
   end

endmodule

// ----- sim/sjf_nonpreemptive_scheduler_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjf_nonpreemptive_scheduler_test: stimulus and verdict for the scheduler
// Sends directed job sets (extremes, ties, idle gaps, zero bursts, overflow)
// and then random sets of mixed size and content, with random idling on both
// channels save in one stretch; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module sjf_nonpreemptive_scheduler_test
   import sjfs_pkg::*;
();

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [TIME_W-1:0] req_arrival_time;
   logic [TIME_W-1:0] req_burst_time;
   logic              req_last_job;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [ID_W-1:0]   rsp_job_id;
   logic [TIME_W-1:0] rsp_job_arrival;
   logic [TIME_W-1:0] rsp_job_burst;
   logic [DUR_W-1:0]  rsp_wait_time;
   logic [DUR_W-1:0]  rsp_turnaround_time;
   logic [SUM_W-1:0]  rsp_total_wait;
   logic [SUM_W-1:0]  rsp_total_turnaround;
   logic [CNT_W-1:0]  rsp_job_count;
   logic              rsp_dropped;
   logic              rsp_last_result;

   int errors;
   int pending;
   int req_idle_pct;
   int rsp_idle_pct;
   int jobs_sent;

   sjf_nonpreemptive_scheduler dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_arrival_time     (req_arrival_time),
      .req_burst_time       (req_burst_time),
      .req_last_job         (req_last_job),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_job_id           (rsp_job_id),
      .rsp_job_arrival      (rsp_job_arrival),
      .rsp_job_burst        (rsp_job_burst),
      .rsp_wait_time        (rsp_wait_time),
      .rsp_turnaround_time  (rsp_turnaround_time),
      .rsp_total_wait       (rsp_total_wait),
      .rsp_total_turnaround (rsp_total_turnaround),
      .rsp_job_count        (rsp_job_count),
      .rsp_dropped          (rsp_dropped),
      .rsp_last_result      (rsp_last_result)
   );

   sjfs_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_arrival_time     (req_arrival_time),
      .req_burst_time       (req_burst_time),
      .req_last_job         (req_last_job),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_job_id           (rsp_job_id),
      .rsp_job_arrival      (rsp_job_arrival),
      .rsp_job_burst        (rsp_job_burst),
      .rsp_wait_time        (rsp_wait_time),
      .rsp_turnaround_time  (rsp_turnaround_time),
      .rsp_total_wait       (rsp_total_wait),
      .rsp_total_turnaround (rsp_total_turnaround),
      .rsp_job_count        (rsp_job_count),
      .rsp_dropped          (rsp_dropped),
      .rsp_last_result      (rsp_last_result),
      .errors               (errors),
      .pending              (pending)
   );

   // 20 ns clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // receiver stalls at random
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // hard stop well beyond the slowest correct run
   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   // one job word; valid stays high into the next word unless an idle cycle
   task automatic send_job(input logic [TIME_W-1:0] arr, input logic [TIME_W-1:0] dur,
                           input logic last);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_arrival_time <= arr;
      req_burst_time   <= dur;
      req_last_job     <= last;
      do @(posedge clock); while (!req_ready);
      jobs_sent++;
   endtask

   initial begin
      int n;
      int j;
      int mode;
      int pick;
      logic [TIME_W-1:0] arr;
      logic [TIME_W-1:0] dur;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_arrival_time = '0;
      req_burst_time   = '0;
      req_last_job     = 1'b0;
      req_idle_pct     = 20;
      rsp_idle_pct     = 20;
      jobs_sent        = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single job, zero burst at tick zero
      send_job(16'd0, 16'd0, 1'b1);
      // single job at the top of the range: idle gap to the last tick
      send_job(16'hffff, 16'hffff, 1'b1);
      // ties on burst broken by arrival then by id, then an idle gap
      send_job(16'd4, 16'd3, 1'b0);
      send_job(16'd0, 16'd10, 1'b0);
      send_job(16'd2, 16'd3, 1'b0);
      send_job(16'd2, 16'd3, 1'b0);
      send_job(16'd200, 16'd0, 1'b1);
      // full set plus two dropped jobs, the closing one among them
      for (j = 0; j < 18; j++)
         send_job(16'hffff, 16'hffff, j == 17);

      // random sets, mostly small
      while (jobs_sent < 425) begin
         if (jobs_sent >= 170 && jobs_sent < 290) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = 20;
            rsp_idle_pct = 20;
         end
         pick = $urandom_range(99);
         if (pick < 60)
            n = $urandom_range(1, 5);
         else if (pick < 85)
            n = $urandom_range(6, 15);
         else if (pick < 95)
            n = 16;
         else
            n = $urandom_range(17, 20);
         mode = $urandom_range(3);
         for (j = 0; j < n; j++) begin
            // arrival spread: crowded, full range, near the top, or sparse
            case (mode)
               0: arr = TIME_W'($urandom_range(0, 7));
               1: arr = TIME_W'($urandom_range(65535));
               2: arr = TIME_W'(16'hffff - $urandom_range(0, 255));
               default: arr = TIME_W'($urandom_range(0, 4095));
            endcase
            // burst spread: tiny for ties, medium, full range, or an extreme
            case ($urandom_range(3))
               0: dur = TIME_W'($urandom_range(0, 3));
               1: dur = TIME_W'($urandom_range(0, 255));
               2: dur = TIME_W'($urandom_range(65535));
               default: dur = $urandom_range(1) ? 16'hffff : 16'h0000;
            endcase
            send_job(arr, dur, j == n - 1);
         end
      end
      req_valid <= 1'b0;

      // drain, then allow stray words to show up
      do @(negedge clock); while (pending != 0);
      repeat (100) @(posedge clock);
      if (errors == 0 && pending == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/sjfs_pkg.sv
rtl/sjfs_cell.sv
rtl/sjf_nonpreemptive_scheduler.sv
sim/sjfs_checker.sv
sim/sjf_nonpreemptive_scheduler_test.sv
